// ===== src/spbs_pkg.sv =====
// Shared types and constants of the pregap boundary search block
`timescale 1ns / 1ps
`default_nettype none

package spbs_pkg;

  // field widths
  localparam int unsigned SECTOR_W = 19;
  localparam int unsigned TRACK_W  = 7;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned CFG_W    = 19;
  localparam int unsigned CFG_IDX_W = 2;

  // default search parameters
  localparam int unsigned DEF_SEARCH_WINDOW = 450;
  localparam int unsigned DEF_BACK_STEPS    = 8;
  localparam int unsigned DEF_CONFIRM_RUN   = 3;
  localparam int unsigned DEF_MIN_FIRST_GAP = 150;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TRACK     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_START      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TRACK_RULE = 2'd2;

  // configuration register set
  typedef struct packed {
    logic [TRACK_W-1:0]  target_track;
    logic [SECTOR_W-1:0] track_start;
    logic                first_track_rule;
  } cfg_t;

  // one input request
  typedef struct packed {
    logic               mode;
    logic               read_ok;
    logic [TRACK_W-1:0] q_track;
    logic [INDEX_W-1:0] q_index;
  } in_t;

  // one result
  typedef struct packed {
    logic                request_valid;
    logic [SECTOR_W-1:0] request_sector;
    logic                done_res;
    logic                confirmed;
    logic [SECTOR_W-1:0] pregap_start;
  } out_t;

endpackage

`default_nettype wire

// ===== src/spbs_if.sv =====
// Valid/ready channel interfaces for input requests and results
`timescale 1ns / 1ps
`default_nettype none

interface spbs_req_if
  import spbs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               mode;
  logic               read_ok;
  logic [TRACK_W-1:0] q_track;
  logic [INDEX_W-1:0] q_index;

  modport source (output valid, output mode, output read_ok, output q_track,
                  output q_index, input ready);
  modport sink (input valid, input mode, input read_ok, input q_track,
                input q_index, output ready);
endinterface

interface spbs_res_if
  import spbs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                request_valid;
  logic [SECTOR_W-1:0] request_sector;
  logic                done_res;
  logic                confirmed;
  logic [SECTOR_W-1:0] pregap_start;

  modport source (output valid, output request_valid, output request_sector,
                  output done_res, output confirmed, output pregap_start,
                  input ready);
  modport sink (input valid, input request_valid, input request_sector,
                input done_res, input confirmed, input pregap_start,
                output ready);
endinterface

`default_nettype wire

// ===== src/spbs_cfg_regs.sv =====
// Configuration register file of the pregap boundary search
`timescale 1ns / 1ps
`default_nettype none

module spbs_cfg_regs
  import spbs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode the write, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_TRACK:     cfg_d.target_track     = cfg_wdata_i[TRACK_W-1:0];
        CFG_TRACK_START:      cfg_d.track_start      = cfg_wdata_i[SECTOR_W-1:0];
        CFG_FIRST_TRACK_RULE: cfg_d.first_track_rule = cfg_wdata_i[0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_track     <= TRACK_W'(1);
      cfg_q.track_start      <= '0;
      cfg_q.first_track_rule <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/spbs_step.sv =====
// Search state registers and the per-reading update logic
`timescale 1ns / 1ps
`default_nettype none

module spbs_step
  import spbs_pkg::*;
#(
  parameter int unsigned SEARCH_WINDOW = DEF_SEARCH_WINDOW,
  parameter int unsigned BACK_STEPS    = DEF_BACK_STEPS,
  parameter int unsigned CONFIRM_RUN   = DEF_CONFIRM_RUN,
  parameter int unsigned MIN_FIRST_GAP = DEF_MIN_FIRST_GAP
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire in_t  req_i,
  input  wire cfg_t cfg_i,
  output out_t      res_o
);

  localparam int unsigned RUN_W = $clog2(CONFIRM_RUN + 1);
  localparam logic [RUN_W-1:0]    RUN_MAX = RUN_W'(CONFIRM_RUN);
  localparam logic [SECTOR_W-1:0] WIN19   = SECTOR_W'(SEARCH_WINDOW);
  localparam logic [SECTOR_W-1:0] BACK19  = SECTOR_W'(BACK_STEPS);
  localparam logic [SECTOR_W:0]   BACK20  = (SECTOR_W + 1)'(BACK_STEPS);
  localparam logic [SECTOR_W-1:0] GAP19   = SECTOR_W'(MIN_FIRST_GAP);

  // phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_FWD  = 2'd1;
  localparam logic [1:0] PH_BACK = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]          phase_q, phase_d;
  logic [SECTOR_W-1:0] cur_q, cur_d;
  logic [SECTOR_W-1:0] ws_q, ws_d;
  logic [SECTOR_W-1:0] bl_q, bl_d;
  logic [SECTOR_W-1:0] fi_q, fi_d;
  logic                found_q, found_d;
  logic [RUN_W-1:0]    run_q, run_d;

  logic match, is0, conf_q, conf_v, stop, go_back;
  logic [SECTOR_W-1:0] ts, win_start, bl_v;
  out_t res;

  // final result from the run state
  function automatic out_t done_f(logic conf, logic [SECTOR_W-1:0] fi,
                                  logic [SECTOR_W-1:0] tstart, logic ftr);
    logic [SECTOR_W:0] gap;
    logic              gap_ok;
    out_t              r;
    begin
      r      = '0;
      gap    = {1'b0, tstart} - {1'b0, fi};
      // a negative gap wraps to a huge one and always passes
      gap_ok = gap[SECTOR_W] || (gap[SECTOR_W-1:0] >= GAP19);
      r.done_res  = 1'b1;
      r.confirmed = conf;
      if (ftr) begin
        r.pregap_start = (conf && gap_ok) ? fi : '0;
      end else begin
        r.pregap_start = conf ? fi : tstart;
      end
      done_f = r;
    end
  endfunction

  assign ts        = cfg_i.track_start;
  assign match     = req_i.read_ok && (req_i.q_track == cfg_i.target_track);
  assign is0       = match && (req_i.q_index == '0);
  assign conf_q    = found_q && (run_q >= RUN_MAX);
  assign win_start = (ts > WIN19) ? (ts - WIN19) : '0;

  // one step of the search sequencer
  always_comb begin
    phase_d = phase_q;
    cur_d   = cur_q;
    ws_d    = ws_q;
    bl_d    = bl_q;
    fi_d    = fi_q;
    found_d = found_q;
    run_d   = run_q;
    res     = '0;
    conf_v  = conf_q;
    stop    = 1'b0;
    go_back = 1'b0;
    bl_v    = ws_q;
    if (!req_i.mode) begin
      // start command opens the window
      ws_d    = win_start;
      cur_d   = win_start;
      fi_d    = ts;
      found_d = 1'b0;
      run_d   = '0;
      bl_d    = '0;
      if (win_start >= ts) begin
        phase_d = PH_DONE;
        res     = done_f(1'b0, ts, ts, cfg_i.first_track_rule);
      end else begin
        phase_d              = PH_FWD;
        res.request_valid    = 1'b1;
        res.request_sector   = win_start;
      end
    end else begin
      case (phase_q)
        PH_FWD: begin
          // run tracking
          if (is0) begin
            if (!found_q) begin
              fi_d    = cur_q;
              found_d = 1'b1;
              run_d   = RUN_W'(1);
            end else if (run_q < RUN_MAX) begin
              run_d = run_q + RUN_W'(1);
            end
          end else begin
            if (found_q && (run_q < RUN_MAX)) begin
              found_d = 1'b0;
              run_d   = '0;
              fi_d    = ts;
            end
            stop = found_d && (run_d >= RUN_MAX) && match &&
                   (req_i.q_index == INDEX_W'(1));
          end
          conf_v = found_d && (run_d >= RUN_MAX);
          cur_d  = cur_q + SECTOR_W'(1);
          if (stop || (cur_d >= ts) || (cur_d == '0)) begin
            // end of forward scan: refine backward or finish
            if (conf_v && (fi_d > ws_q)) begin
              bl_v = ({1'b0, fi_d} > ({1'b0, ws_q} + BACK20)) ? (fi_d - BACK19) : ws_q;
              if (bl_v < fi_d) begin
                go_back = 1'b1;
              end
            end
            if (go_back) begin
              bl_d               = bl_v;
              cur_d              = fi_d - SECTOR_W'(1);
              phase_d            = PH_BACK;
              res.request_valid  = 1'b1;
              res.request_sector = fi_d - SECTOR_W'(1);
            end else begin
              phase_d = PH_DONE;
              res     = done_f(conf_v, fi_d, ts, cfg_i.first_track_rule);
            end
          end else begin
            res.request_valid  = 1'b1;
            res.request_sector = cur_d;
          end
        end
        PH_BACK: begin
          if (is0) begin
            fi_d = cur_q;
            if ((cur_q <= bl_q) || (cur_q == '0)) begin
              phase_d = PH_DONE;
              res     = done_f(conf_q, cur_q, ts, cfg_i.first_track_rule);
            end else begin
              cur_d              = cur_q - SECTOR_W'(1);
              res.request_valid  = 1'b1;
              res.request_sector = cur_q - SECTOR_W'(1);
            end
          end else begin
            phase_d = PH_DONE;
            res     = done_f(conf_q, fi_q, ts, cfg_i.first_track_rule);
          end
        end
        PH_DONE: begin
          res = done_f(conf_q, fi_q, ts, cfg_i.first_track_rule);
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cur_q   <= '0;
      ws_q    <= '0;
      bl_q    <= '0;
      fi_q    <= '0;
      found_q <= 1'b0;
      run_q   <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      ws_q    <= ws_d;
      bl_q    <= bl_d;
      fi_q    <= fi_d;
      found_q <= found_d;
      run_q   <= run_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

// ===== src/subchannel_pregap_boundary_search.sv =====
// Top level of the pregap boundary search sequencer
//
// Finds where index 00 of a CD track begins. A start request opens a window of
// up to SEARCH_WINDOW sectors before track_start; each following request carries
// the Q reading of the sector last asked for and returns either the next sector
// to read or the final pregap start. One request is taken every clock cycle when
// the input side does not stall. The state update computes the result from the
// request held in the input register and the search state registers, and the
// result register loads it once empty or once its result is taken. While a
// result waits the input side still takes one request into the input register,
// and stalls only when both the input and the result registers are full and the
// result is not taken. The user writes configuration through a plain write port
// only while no search step is in flight; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module subchannel_pregap_boundary_search
  import spbs_pkg::*;
#(
  parameter int unsigned SEARCH_WINDOW = DEF_SEARCH_WINDOW,
  parameter int unsigned BACK_STEPS    = DEF_BACK_STEPS,
  parameter int unsigned CONFIRM_RUN   = DEF_CONFIRM_RUN,
  parameter int unsigned MIN_FIRST_GAP = DEF_MIN_FIRST_GAP
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  spbs_req_if.sink                  req_in,
  spbs_res_if.source                res_out,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t cfg;
  in_t  in_q, in_d;
  out_t res_q, step_res;
  logic in_vld_q, in_vld_d;
  logic res_vld_q, res_vld_d;
  logic adv, acc;

  // configuration registers
  spbs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // handshake and stage advance
  assign adv          = in_vld_q && (!res_vld_q || res_out.ready);
  assign req_in.ready = !in_vld_q || adv;
  assign acc          = req_in.valid && req_in.ready;

  always_comb begin
    in_d.mode    = req_in.mode;
    in_d.read_ok = req_in.read_ok;
    in_d.q_track = req_in.q_track;
    in_d.q_index = req_in.q_index;
    in_vld_d     = acc ? 1'b1 : (adv ? 1'b0 : in_vld_q);
    res_vld_d    = adv ? 1'b1 : (res_out.ready ? 1'b0 : res_vld_q);
  end

  // search state update
  spbs_step #(
    .SEARCH_WINDOW (SEARCH_WINDOW),
    .BACK_STEPS    (BACK_STEPS),
    .CONFIRM_RUN   (CONFIRM_RUN),
    .MIN_FIRST_GAP (MIN_FIRST_GAP)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .req_i  (in_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      in_q <= in_d;
    end
    if (adv) begin
      res_q <= step_res;
    end
  end

  assign res_out.valid          = res_vld_q;
  assign res_out.request_valid  = res_q.request_valid;
  assign res_out.request_sector = res_q.request_sector;
  assign res_out.done_res       = res_q.done_res;
  assign res_out.confirmed      = res_q.confirmed;
  assign res_out.pregap_start   = res_q.pregap_start;

endmodule

`default_nettype wire

// ===== src/spbs_checker.sv =====
// Port-level checks of the pregap boundary search and their binding
`timescale 1ns / 1ps
`default_nettype none

module spbs_checker
  import spbs_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                res_valid_i,
  input wire logic                res_ready_i,
  input wire logic                request_valid_i,
  input wire logic [SECTOR_W-1:0] request_sector_i,
  input wire logic                done_res_i,
  input wire logic                confirmed_i,
  input wire logic [SECTOR_W-1:0] pregap_start_i
);

  // stalled result holds its contents
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(request_valid_i) &&
    $stable(request_sector_i) && $stable(done_res_i) && $stable(confirmed_i) &&
    $stable(pregap_start_i))
    else $error("stalled result changed");

  // a result is never both a request and a final report
  a_req_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !(request_valid_i && done_res_i))
    else $error("request and done in one result");

  // report fields stay clear until the search ends
  a_not_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !done_res_i |-> !confirmed_i && (pregap_start_i == '0))
    else $error("report fields set before done");

  // no sector named without a request
  a_no_req_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !request_valid_i |-> (request_sector_i == '0))
    else $error("sector set without request");

endmodule

bind subchannel_pregap_boundary_search spbs_checker u_spbs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_out.valid),
  .res_ready_i      (res_out.ready),
  .request_valid_i  (res_out.request_valid),
  .request_sector_i (res_out.request_sector),
  .done_res_i       (res_out.done_res),
  .confirmed_i      (res_out.confirmed),
  .pregap_start_i   (res_out.pregap_start)
);

`default_nettype wire
